[sv/assert_macros.svh]
// Assertion macros shared by the RTL.
// Depends on nothing; users provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must hold every clock
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

[sv/rfem_pkg.sv]
// Package for the range flag extent map: sizes, status codes, command codes, table entry type.
// Depends on nothing.
package rfem_pkg;

    localparam int MAX_EXTENTS  = 1024;
    localparam int CLUSTER_BITS = 48;
    localparam int FLAG_BITS    = 8;
    localparam int LEN_W        = CLUSTER_BITS + 1;
    localparam int IDX_W        = $clog2(MAX_EXTENTS);
    localparam int CNT_W        = $clog2(MAX_EXTENTS + 3);
    localparam int ADDR_W       = IDX_W + 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic CMD_MARK = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    typedef struct packed {
        logic [CLUSTER_BITS-1:0] start;
        logic [LEN_W-1:0]        len;
        logic [FLAG_BITS-1:0]    flags;
    } entry_t;

endpackage

[sv/range_flag_extent_map_top.sv]
// Range flag extent map: top level with the extent table memory and its sequencer.
// Depends on rfem_pkg and assert_macros.svh.
//
// The extent table lives in one memory of two banks. A find scans the live bank
// from the first entry until the hit or the last live entry. A mark streams every
// live entry through a read/split/merge sequencer into the other bank and swaps
// banks on success; on table full the live bank stays. A size write rebuilds the
// table at once, no clearing pass. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
`include "assert_macros.svh"

module range_flag_extent_map_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [rfem_pkg::LEN_W-1:0]        cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [rfem_pkg::CLUSTER_BITS-1:0] first_cluster,
    input  logic [rfem_pkg::LEN_W-1:0]        cluster_count,
    input  logic [rfem_pkg::FLAG_BITS-1:0]    set_flags,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [rfem_pkg::CLUSTER_BITS-1:0] extent_start,
    output logic [rfem_pkg::LEN_W-1:0]        extent_length,
    output logic [rfem_pkg::FLAG_BITS-1:0]    extent_flags
);
    import rfem_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FRD    = 9'b000000010,
        S_FCK    = 9'b000000100,
        S_MRD    = 9'b000001000,
        S_MLD    = 9'b000010000,
        S_MCALC  = 9'b000100000,
        S_MPUSH  = 9'b001000000,
        S_MFLUSH = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    localparam logic [LEN_W-1:0] TOP_SIZE = {1'b1, {CLUSTER_BITS{1'b0}}};

    state_t state_reg, state_next;

    entry_t mem [2**ADDR_W];
    entry_t mem_q_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    entry_t            mem_wdata;
    logic              mem_re;

    logic [LEN_W-1:0]        total_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    bank_reg, bank_next;
    logic                    fresh_reg, fresh_next;

    logic [CLUSTER_BITS-1:0] off_reg, off_next;
    logic [LEN_W-1:0]        end_reg, end_next;
    logic [FLAG_BITS-1:0]    fl_reg, fl_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        wcnt_reg, wcnt_next;

    entry_t                  ent_reg, ent_next;
    logic [LEN_W-1:0]        ee_reg, ee_next;
    logic                    chg_reg, chg_next, has_l_reg, has_l_next, has_r_reg, has_r_next;
    logic [CLUSTER_BITS-1:0] m_start_reg, m_start_next;
    logic [LEN_W-1:0]        m_len_reg, m_len_next, l_len_reg, l_len_next;
    logic [LEN_W-1:0]        r_len_reg, r_len_next;
    logic [1:0]              phase_reg, phase_next;

    entry_t                  pend_reg, pend_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    open_reg, open_next;

    logic [1:0]              res_status_reg, res_status_next;
    entry_t                  res_ent_reg, res_ent_next;

    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    entry_t                  out_ent_reg;

    entry_t                  rd_ent;
    logic                    last_idx;
    logic [LEN_W-1:0]        room;
    logic [LEN_W-1:0]        cfg_clamped;
    logic [FLAG_BITS-1:0]    new_fl;
    logic [LEN_W-1:0]        m_end;
    logic [LEN_W-1:0]        off_w, es_w;
    logic                    ovl;
    entry_t                  piece;
    logic                    piece_on, piece_merge, piece_open;

    assign rd_ent   = fresh_reg ? entry_t'{start: '0, len: total_reg, flags: '0} : mem_q_reg;
    assign last_idx = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;
    assign room     = total_reg - {1'b0, first_cluster};
    assign new_fl   = ent_reg.flags | fl_reg;
    assign off_w    = {1'b0, off_reg};
    assign es_w     = {1'b0, ent_reg.start};
    assign ovl      = (es_w < end_reg) && (ee_reg > off_w);
    assign m_end    = has_r_reg ? end_reg : ee_reg;

    always_comb
    begin
        if (cfg_write_data == '0)
            cfg_clamped = LEN_W'(1);
        else if (cfg_write_data > TOP_SIZE)
            cfg_clamped = TOP_SIZE;
        else
            cfg_clamped = cfg_write_data;
    end

    always_comb
    begin
        piece       = ent_reg;
        piece_on    = 1'b0;
        piece_merge = 1'b0;
        piece_open  = 1'b0;
        unique case (phase_reg)
            2'd0:
            begin
                piece_on = chg_reg && has_l_reg;
                piece    = entry_t'{start: ent_reg.start, len: l_len_reg, flags: ent_reg.flags};
            end
            2'd1:
            begin
                piece_on = 1'b1;
                if (chg_reg)
                begin
                    piece       = entry_t'{start: m_start_reg, len: m_len_reg, flags: new_fl};
                    piece_merge = pend_valid_reg && (pend_reg.flags == new_fl);
                    piece_open  = !has_r_reg;
                end
                else
                begin
                    piece_merge = open_reg && (pend_reg.flags == ent_reg.flags);
                end
            end
            2'd2:
            begin
                piece_on = chg_reg && has_r_reg;
                piece    = entry_t'{start: end_reg[CLUSTER_BITS-1:0], len: r_len_reg,
                                    flags: ent_reg.flags};
            end
            default:
            begin
                piece_on = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        bank_next       = bank_reg;
        fresh_next      = fresh_reg;
        off_next        = off_reg;
        end_next        = end_reg;
        fl_next         = fl_reg;
        idx_next        = idx_reg;
        wcnt_next       = wcnt_reg;
        ent_next        = ent_reg;
        ee_next         = ee_reg;
        chg_next        = chg_reg;
        has_l_next      = has_l_reg;
        has_r_next      = has_r_reg;
        m_start_next    = m_start_reg;
        m_len_next      = m_len_reg;
        l_len_next      = l_len_reg;
        r_len_next      = r_len_reg;
        phase_next      = phase_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        open_next       = open_reg;
        res_status_next = res_status_reg;
        res_ent_next    = res_ent_reg;
        mem_we          = 1'b0;
        mem_waddr       = {~bank_reg, wcnt_reg[IDX_W-1:0]};
        mem_wdata       = pend_reg;
        mem_re          = 1'b0;
        mem_raddr       = {bank_reg, idx_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    off_next        = first_cluster;
                    end_next        = {1'b0, first_cluster} + cluster_count;
                    fl_next         = set_flags;
                    idx_next        = '0;
                    wcnt_next       = '0;
                    pend_valid_next = 1'b0;
                    open_next       = 1'b0;
                    res_ent_next    = '0;
                    res_status_next = ST_OK;
                    if ({1'b0, first_cluster} >= total_reg)
                    begin
                        res_status_next = (command == CMD_MARK && cluster_count == '0)
                                          ? ST_ZERO : ST_OUTSIDE;
                        state_next      = S_DONE;
                    end
                    else if (command == CMD_FIND)
                        state_next = S_FRD;
                    else if (cluster_count == '0)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else if (cluster_count > room)
                    begin
                        res_status_next = ST_OUTSIDE;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_MRD;
                end
            end
            S_FRD:
            begin
                mem_re     = 1'b1;
                state_next = S_FCK;
            end
            S_FCK:
            begin
                if (rd_ent.start <= off_reg && (off_w - {1'b0, rd_ent.start}) < rd_ent.len)
                begin
                    res_ent_next = rd_ent;
                    state_next   = S_DONE;
                end
                else if (last_idx)
                begin
                    res_status_next = ST_OUTSIDE;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_FRD;
                end
            end
            S_MRD:
            begin
                mem_re     = 1'b1;
                state_next = S_MLD;
            end
            S_MLD:
            begin
                ent_next   = rd_ent;
                ee_next    = {1'b0, rd_ent.start} + rd_ent.len;
                state_next = S_MCALC;
            end
            S_MCALC:
            begin
                chg_next     = ovl && ((ent_reg.flags & fl_reg) != fl_reg);
                has_l_next   = ent_reg.start < off_reg;
                has_r_next   = ee_reg > end_reg;
                m_start_next = (ent_reg.start < off_reg) ? off_reg : ent_reg.start;
                l_len_next   = off_w - es_w;
                r_len_next   = ee_reg - end_reg;
                phase_next   = 2'd0;
                state_next   = S_MPUSH;
            end
            S_MPUSH:
            begin
                if (phase_reg == 2'd0)
                    m_len_next = m_end - {1'b0, m_start_reg};
                if (piece_on)
                begin
                    open_next = piece_open;
                    if (piece_merge)
                        pend_next.len = pend_reg.len + piece.len;
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            mem_we    = wcnt_reg < CNT_W'(MAX_EXTENTS);
                            wcnt_next = wcnt_reg + CNT_W'(1);
                        end
                        pend_next       = piece;
                        pend_valid_next = 1'b1;
                    end
                end
                if (phase_reg == 2'd2)
                begin
                    if (last_idx)
                        state_next = S_MFLUSH;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_MRD;
                    end
                end
                else
                    phase_next = phase_reg + 2'd1;
            end
            S_MFLUSH:
            begin
                mem_we     = wcnt_reg < CNT_W'(MAX_EXTENTS);
                state_next = S_DONE;
                if (wcnt_reg >= CNT_W'(MAX_EXTENTS))
                    res_status_next = ST_FULL;
                else
                begin
                    count_next = wcnt_reg + CNT_W'(1);
                    bank_next  = ~bank_reg;
                    fresh_next = 1'b0;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write_en)
        begin
            count_next = CNT_W'(1);
            fresh_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= LEN_W'(1);
            count_reg      <= CNT_W'(1);
            bank_reg       <= 1'b0;
            fresh_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            bank_reg       <= bank_next;
            fresh_reg      <= fresh_next;
            pend_valid_reg <= pend_valid_next;
            open_reg       <= open_next;
            if (cfg_write_en)
                total_reg <= cfg_clamped;
            if (state_reg == S_DONE && state_next == S_IDLE)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        end_reg        <= end_next;
        fl_reg         <= fl_next;
        idx_reg        <= idx_next;
        wcnt_reg       <= wcnt_next;
        ent_reg        <= ent_next;
        ee_reg         <= ee_next;
        chg_reg        <= chg_next;
        has_l_reg      <= has_l_next;
        has_r_reg      <= has_r_next;
        m_start_reg    <= m_start_next;
        m_len_reg      <= m_len_next;
        l_len_reg      <= l_len_next;
        r_len_reg      <= r_len_next;
        phase_reg      <= phase_next;
        pend_reg       <= pend_next;
        res_status_reg <= res_status_next;
        res_ent_reg    <= res_ent_next;
        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            status_reg  <= res_status_reg;
            out_ent_reg <= res_ent_reg;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign extent_start  = out_ent_reg.start;
    assign extent_length = out_ent_reg.len;
    assign extent_flags  = out_ent_reg.flags;

    `ASSERT_ALWAYS(a_count_range, count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_EXTENTS),
                   "extent count out of range")
    `ASSERT_IMP(a_we_in_mark, mem_we, state_reg == S_MPUSH || state_reg == S_MFLUSH,
                "table write outside a mark")
    `ASSERT_IMP(a_fresh_single, fresh_reg, count_reg == CNT_W'(1),
                "rebuilt table must hold one extent")
    `ASSERT_IMP(a_flush_pend, state_reg == S_MFLUSH, pend_valid_reg,
                "flush without a pending extent")

endmodule

[tb/tb_range_flag_extent_map_top.sv]
// Testbench for range_flag_extent_map_top: directed table, random phases and a table-fill run,
// each result checked against a typed expectation or a built-in extent table model.
// Depends on rfem_pkg and the RTL top level.
module tb_range_flag_extent_map_top;
    import rfem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WORK_DEPTH  = MAX_EXTENTS + 2;
    localparam longint      CYCLE_LIMIT = 12000000;
    localparam logic [63:0] FULL_MAP    = 64'd1 << CLUSTER_BITS;

    typedef struct packed {
        logic [1:0]              status;
        logic [CLUSTER_BITS-1:0] start;
        logic [LEN_W-1:0]        len;
        logic [FLAG_BITS-1:0]    flags;
    } result_t;

    typedef struct {
        bit          is_size;
        logic        cmd;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  fl;
        bit          typed;
        result_t     want;
    } row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write_en = 1'b0;
    logic [LEN_W-1:0]        cfg_write_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    command = CMD_FIND;
    logic [CLUSTER_BITS-1:0] first_cluster = '0;
    logic [LEN_W-1:0]        cluster_count = '0;
    logic [FLAG_BITS-1:0]    set_flags = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              status;
    logic [CLUSTER_BITS-1:0] extent_start;
    logic [LEN_W-1:0]        extent_length;
    logic [FLAG_BITS-1:0]    extent_flags;

    range_flag_extent_map_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .first_cluster(first_cluster),
        .cluster_count(cluster_count), .set_flags(set_flags),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .extent_start(extent_start),
        .extent_length(extent_length), .extent_flags(extent_flags)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // extent table model
    logic [63:0] map_size;
    entry_t      ext_tbl[MAX_EXTENTS];
    int          ext_cnt;
    result_t     pending_results[$];
    int          mismatches = 0;
    longint      cycles = 0;
    bit          calm = 1'b0;

    function automatic void rebuild_map(logic [63:0] size);
        map_size = size;
        foreach (ext_tbl[k]) ext_tbl[k] = '0;
        ext_tbl[0].len = size[LEN_W-1:0];
        ext_cnt = 1;
    endfunction

    function automatic logic [1:0] mark_range(logic [63:0] off, logic [63:0] len,
                                              logic [7:0] fl);
        entry_t      w[$];
        entry_t      e;
        logic [63:0] end_c, pos, nl, es, el;
        int          i;
        bit          cut_l, cut_r;
        end_c = off + len;
        pos = off;
        for (int k = 0; k < ext_cnt; k++) w.push_back(ext_tbl[k]);
        while (pos < end_c)
        begin
            i = w.size();
            for (int k = 0; k < w.size(); k++)
            begin
                es = w[k].start;
                el = w[k].len;
                if (es <= pos && pos - es < el)
                begin
                    i = k;
                    break;
                end
            end
            if (i >= w.size()) break;
            if ((w[i].flags & fl) == fl)
            begin
                pos = 64'(w[i].start) + 64'(w[i].len);
                continue;
            end
            cut_l = 64'(w[i].start) < off;
            if (cut_l)
            begin
                nl = 64'(w[i].start) + 64'(w[i].len) - off;
                if (w.size() >= WORK_DEPTH) return ST_FULL;
                e.start = off[CLUSTER_BITS-1:0];
                e.len = nl[LEN_W-1:0];
                e.flags = w[i].flags;
                w.insert(i + 1, e);
                w[i].len = w[i].len - nl[LEN_W-1:0];
                i++;
            end
            cut_r = 64'(w[i].start) + 64'(w[i].len) > end_c;
            if (cut_r)
            begin
                nl = 64'(w[i].start) + 64'(w[i].len) - end_c;
                if (w.size() >= WORK_DEPTH) return ST_FULL;
                e.start = end_c[CLUSTER_BITS-1:0];
                e.len = nl[LEN_W-1:0];
                e.flags = w[i].flags;
                w.insert(i + 1, e);
                w[i].len = w[i].len - nl[LEN_W-1:0];
            end
            w[i].flags = w[i].flags | fl;
            if (!cut_l && i > 0 && w[i-1].flags == w[i].flags)
            begin
                w[i-1].len = w[i-1].len + w[i].len;
                w.delete(i);
                i--;
            end
            if (!cut_r && i + 1 < w.size() && w[i+1].flags == w[i].flags)
            begin
                w[i].len = w[i].len + w[i+1].len;
                w.delete(i + 1);
            end
            pos = 64'(w[i].start) + 64'(w[i].len);
        end
        if (w.size() > MAX_EXTENTS) return ST_FULL;
        for (int k = 0; k < MAX_EXTENTS; k++) ext_tbl[k] = (k < w.size()) ? w[k] : '0;
        ext_cnt = w.size();
        return ST_OK;
    endfunction

    function automatic result_t predict_result(logic cmd, logic [63:0] off,
                                               logic [63:0] len, logic [7:0] fl);
        result_t r;
        logic [63:0] es, el;
        r = '0;
        if (cmd == CMD_FIND)
        begin
            r.status = ST_OUTSIDE;
            if (off < map_size)
                for (int k = 0; k < ext_cnt; k++)
                begin
                    es = ext_tbl[k].start;
                    el = ext_tbl[k].len;
                    if (es <= off && off - es < el)
                    begin
                        r.status = ST_OK;
                        r.start = ext_tbl[k].start;
                        r.len = ext_tbl[k].len;
                        r.flags = ext_tbl[k].flags;
                        break;
                    end
                end
        end
        else if (len == 0)
            r.status = ST_ZERO;
        else if (off >= map_size || len > map_size - off)
            r.status = ST_OUTSIDE;
        else
            r.status = mark_range(off, len, fl);
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    task automatic write_size(logic [63:0] value);
        logic [63:0] v;
        wait_drained();
        repeat (8) @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_write_data = value[LEN_W-1:0];
        @(negedge clk);
        cfg_write_en = 1'b0;
        v = value & ((64'd1 << LEN_W) - 1);
        if (v == 0) v = 1;
        if (v > FULL_MAP) v = FULL_MAP;
        rebuild_map(v);
    endtask

    // one input transfer; expectation is taken when the block accepts it
    task automatic send_item(logic cmd, logic [63:0] a, logic [63:0] b, logic [7:0] fl,
                             bit typed, result_t want);
        result_t r;
        if (!calm && $urandom_range(0, 99) < 25) repeat ($urandom_range(1, 6)) @(negedge clk);
        in_valid = 1'b1;
        command = cmd;
        first_cluster = a[CLUSTER_BITS-1:0];
        cluster_count = b[LEN_W-1:0];
        set_flags = fl;
        do @(posedge clk); while (in_stall);
        r = predict_result(cmd, 64'(first_cluster), 64'(cluster_count), fl);
        pending_results.push_back(typed ? want : r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        logic [63:0] off, rem, len;
        logic [7:0]  fl;
        fl = ($urandom_range(0, 1) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            send_item(1'($urandom), rand64(), ($urandom_range(0, 3) == 0) ? 64'd0 : rand64(),
                      8'($urandom), 1'b0, '0);
        else if ($urandom_range(0, 9) < 3)
            send_item(CMD_FIND, rand64() % map_size, rand64(), fl, 1'b0, '0);
        else
        begin
            off = rand64() % map_size;
            rem = map_size - off;
            if ($urandom_range(0, 3) == 0) len = 1 + rand64() % rem;
            else len = 1 + rand64() % ((rem < 16) ? rem : 64'd16);
            send_item(CMD_MARK, off, len, fl, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall = !calm && rst_n && ($urandom_range(0, 99) < 25);

    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, extent_start, extent_length, extent_flags};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %p", got);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got != exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d s=%h l=%h f=%h, got st=%0d s=%h l=%h f=%h",
                                 exp_r.status, exp_r.start, exp_r.len, exp_r.flags,
                                 got.status, got.start, got.len, got.flags);
                end
            end
        end
    end

    function automatic row_t mk(bit is_size, logic cmd, logic [63:0] a, logic [63:0] b,
                                logic [7:0] fl, bit typed, logic [1:0] st,
                                logic [63:0] s, logic [63:0] l, logic [7:0] f);
        row_t r;
        r.is_size = is_size;
        r.cmd = cmd;
        r.a = a;
        r.b = b;
        r.fl = fl;
        r.typed = typed;
        r.want = '{st, s[CLUSTER_BITS-1:0], l[LEN_W-1:0], f};
        return r;
    endfunction

    initial
    begin
        row_t        rows[$];
        logic [63:0] sizes[5];
        logic [63:0] top_c;
        rebuild_map(64'd1);
        top_c = FULL_MAP - 1;
        rows.push_back(mk(0, CMD_FIND, 0, 0, 0, 1, ST_OK, 0, 1, 0));
        rows.push_back(mk(0, CMD_FIND, 1, 0, 0, 1, ST_OUTSIDE, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 0, 0, 1, 1, ST_ZERO, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 0, 2, 1, 1, ST_OUTSIDE, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 0, 1, 0, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 0, 1, 8'h80, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, 0, 0, 0, 1, ST_OK, 0, 1, 8'h80));
        rows.push_back(mk(1, CMD_FIND, 0, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, 0, 0, 0, 1, ST_OK, 0, 1, 0));
        rows.push_back(mk(1, CMD_FIND, (64'd1 << LEN_W) - 1, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, top_c, 0, 0, 1, ST_OK, 0, FULL_MAP, 0));
        rows.push_back(mk(0, CMD_MARK, top_c, 1, 8'hFF, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, top_c, 0, 0, 1, ST_OK, top_c, 1, 8'hFF));
        rows.push_back(mk(0, CMD_MARK, 0, FULL_MAP, 8'h01, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 0, (64'd1 << LEN_W) - 1, 1, 1, ST_OUTSIDE, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 64'hAAAA_AAAA_AAAA, 16, 8'h55, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, 64'h5555_5555_5555, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, 64'hAAAA_AAAA_AAAA, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(1, CMD_FIND, 16, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 4, 4, 1, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 6, 4, 2, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, 8, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_MARK, 0, 16, 3, 0, ST_OK, 0, 0, 0));
        rows.push_back(mk(0, CMD_FIND, 15, 0, 0, 1, ST_OK, 0, 16, 3));
        rows.push_back(mk(0, CMD_MARK, 15, 2, 1, 1, ST_OUTSIDE, 0, 0, 0));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[k])
            if (rows[k].is_size) write_size(rows[k].a);
            else send_item(rows[k].cmd, rows[k].a, rows[k].b, rows[k].fl,
                           rows[k].typed, rows[k].want);

        sizes = '{64'd64, FULL_MAP, 64'd1 + $urandom_range(1, 1 << 20),
                  64'd1 + rand64() % FULL_MAP, 64'd8};
        foreach (sizes[p])
        begin
            write_size(sizes[p]);
            calm = (p == 2);
            for (int n = 0; n < 16; n++)
            begin
                if (p == 0 && n == 8) wait_drained();
                random_item();
            end
        end
        calm = 1'b0;

        // single-cluster marks at odd clusters grow the table until it is full
        write_size(64'd2048);
        for (int n = 0; n < 514; n++)
            send_item(CMD_MARK, 64'(2 * n + 1), 1, 8'h01, 1'b0, '0);
        send_item(CMD_FIND, 64'd1021, 0, 0, 1'b0, '0);

        wait_drained();
        repeat (50) @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/rfem_pkg.sv
sv/range_flag_extent_map_top.sv
tb/tb_range_flag_extent_map_top.sv
